### rtl/core/avt_pkg.sv
// Package for the affine vector transform: payload structs, command codes,
// configuration constants and width helpers.
// No dependencies; used by every module under rtl/core.
package avt_pkg;

    // Default number format: signed Q16.16
    localparam int NUM_WIDTH_DEF = 32;
    localparam int FRAC_BITS_DEF = 16;

    // Field widths fixed by the interface
    localparam int FIELD_W   = 32;
    localparam int CMD_W     = 2;
    localparam int CFG_W     = 64;
    localparam int CFG_IDX_W = 4;
    localparam int NUM_REGS  = 8;
    localparam int REG_SEL_W = 3;
    localparam int DIM       = 4;
    localparam int NUM_ELEMS = DIM * DIM;

    // Command codes; the unused code behaves as homogeneous
    localparam logic [CMD_W-1:0] CMD_POINT = 2'd0;
    localparam logic [CMD_W-1:0] CMD_DIR   = 2'd1;
    localparam logic [CMD_W-1:0] CMD_HOMO  = 2'd2;

    // Reset contents of the matrix registers (identity), register 7 first
    localparam logic [NUM_REGS-1:0][CFG_W-1:0] CFG_RESET = {
        64'h0000_0000_0001_0000,   // m32:m33
        64'h0000_0000_0000_0000,   // m30:m31
        64'h0001_0000_0000_0000,   // m22:m23
        64'h0000_0000_0000_0000,   // m20:m21
        64'h0000_0000_0000_0000,   // m12:m13
        64'h0000_0000_0001_0000,   // m10:m11
        64'h0000_0000_0000_0000,   // m02:m03
        64'h0001_0000_0000_0000    // m00:m01
    };

    typedef struct packed {
        logic [CMD_W-1:0]          cmd;
        logic signed [FIELD_W-1:0] vec_x;
        logic signed [FIELD_W-1:0] vec_y;
        logic signed [FIELD_W-1:0] vec_z;
        logic signed [FIELD_W-1:0] vec_w;
    } avt_in_t;

    typedef struct packed {
        logic signed [FIELD_W-1:0] out_x;
        logic signed [FIELD_W-1:0] out_y;
        logic signed [FIELD_W-1:0] out_z;
        logic signed [FIELD_W-1:0] out_w;
        logic                      overflow;
    } avt_out_t;

    // Product width: covers a full product and a translation shifted by the fraction
    function automatic int prod_width(input int num_w, input int frac_b);
        int wide;
        wide = (frac_b > num_w) ? frac_b : num_w;
        return num_w + wide;
    endfunction

endpackage

### rtl/core/avt_cfg_regs.sv
// Matrix configuration registers of the affine vector transform.
// Depends on avt_pkg; presents the 16 matrix elements at NUM_WIDTH bits.
module avt_cfg_regs #(
    parameter int NUM_WIDTH = avt_pkg::NUM_WIDTH_DEF
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   cfg_valid,
    output logic                                   cfg_ready,
    input  logic [avt_pkg::CFG_IDX_W-1:0]          cfg_index,
    input  logic [avt_pkg::CFG_W-1:0]              cfg_data,
    output logic [avt_pkg::NUM_ELEMS-1:0][NUM_WIDTH-1:0] mat
);

    logic [avt_pkg::NUM_REGS-1:0][avt_pkg::CFG_W-1:0] cfg_reg;
    logic                                             wr_hit;

    // Writes are always taken; indexes beyond the list are dropped
    assign cfg_ready = 1'b1;
    assign wr_hit    = cfg_valid &&
                       (cfg_index < avt_pkg::CFG_IDX_W'(avt_pkg::NUM_REGS));

    // Hold the register file
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= avt_pkg::CFG_RESET;
        end
        else if (wr_hit)
        begin
            cfg_reg[cfg_index[avt_pkg::REG_SEL_W-1:0]] <= cfg_data;
        end
    end

    // Split each register into its two elements: even column high, odd column low
    always_comb
    begin
        for (int r = 0; r < avt_pkg::DIM; r++)
        begin
            for (int c = 0; c < avt_pkg::DIM; c++)
            begin
                if (c[0])
                    mat[r*avt_pkg::DIM + c] = cfg_reg[r*2 + c/2][NUM_WIDTH-1:0];
                else
                    mat[r*avt_pkg::DIM + c] = cfg_reg[r*2 + c/2][32 +: NUM_WIDTH];
            end
        end
    end

endmodule

### rtl/core/avt_mult_stage.sv
// First pipeline stage: sixteen element-by-component products, registered.
// Depends on avt_pkg; feeds avt_sum_tree.
module avt_mult_stage #(
    parameter int NUM_WIDTH = avt_pkg::NUM_WIDTH_DEF,
    parameter int FRAC_BITS = avt_pkg::FRAC_BITS_DEF,
    parameter int PROD_W    = avt_pkg::prod_width(NUM_WIDTH, FRAC_BITS)
) (
    input  logic                                         clk,
    input  logic                                         rst_n,
    input  logic [avt_pkg::NUM_ELEMS-1:0][NUM_WIDTH-1:0] mat,
    input  logic                                         up_valid,
    output logic                                         up_ready,
    input  avt_pkg::avt_in_t                             item,
    output logic                                         dn_valid,
    input  logic                                         dn_ready,
    output logic [avt_pkg::NUM_ELEMS-1:0][PROD_W-1:0]    prod,
    output logic                                         homo
);

    logic                                      valid_reg;
    logic                                      advance;
    logic [avt_pkg::NUM_ELEMS-1:0][PROD_W-1:0] prod_reg;
    logic [avt_pkg::NUM_ELEMS-1:0][PROD_W-1:0] prod_next;
    logic                                      homo_reg;
    logic                                      homo_next;
    logic signed [NUM_WIDTH-1:0]               opnd [avt_pkg::DIM];
    logic signed [2*NUM_WIDTH-1:0]             mprod [avt_pkg::NUM_ELEMS];
    logic signed [PROD_W-1:0]                  shifted [avt_pkg::DIM];

    assign advance  = !valid_reg || dn_ready;
    assign up_ready = advance;

    // Take the low NUM_WIDTH bits of each component
    always_comb
    begin
        opnd[0] = item.vec_x[NUM_WIDTH-1:0];
        opnd[1] = item.vec_y[NUM_WIDTH-1:0];
        opnd[2] = item.vec_z[NUM_WIDTH-1:0];
        opnd[3] = item.vec_w[NUM_WIDTH-1:0];
    end

    // Form the products; column three follows the command
    always_comb
    begin
        homo_next = (item.cmd != avt_pkg::CMD_POINT) && (item.cmd != avt_pkg::CMD_DIR);
        for (int r = 0; r < avt_pkg::DIM; r++)
        begin
            for (int c = 0; c < avt_pkg::DIM; c++)
            begin
                mprod[r*avt_pkg::DIM + c] = $signed(mat[r*avt_pkg::DIM + c]) * opnd[c];
                prod_next[r*avt_pkg::DIM + c] = PROD_W'(mprod[r*avt_pkg::DIM + c]);
            end
            // Point: translation scaled by 1.0; direction: translation dropped
            shifted[r] = PROD_W'($signed(mat[r*avt_pkg::DIM + 3])) <<< FRAC_BITS;
            if (item.cmd == avt_pkg::CMD_POINT)
                prod_next[r*avt_pkg::DIM + 3] = shifted[r];
            else if (item.cmd == avt_pkg::CMD_DIR)
                prod_next[r*avt_pkg::DIM + 3] = '0;
        end
    end

    // Advance the stage valid bit
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (advance)
            valid_reg <= up_valid;
    end

    // Load the products when a request moves in
    always_ff @(posedge clk)
    begin
        if (advance && up_valid)
        begin
            prod_reg <= prod_next;
            homo_reg <= homo_next;
        end
    end

    assign dn_valid = valid_reg;
    assign prod     = prod_reg;
    assign homo     = homo_reg;

endmodule

### rtl/core/avt_sum_tree.sv
// Second and third pipeline stages: pairwise sums, then full row sums.
// Depends on avt_pkg; takes products from avt_mult_stage, feeds avt_sat_stage.
module avt_sum_tree #(
    parameter int PROD_W = avt_pkg::prod_width(avt_pkg::NUM_WIDTH_DEF,
                                               avt_pkg::FRAC_BITS_DEF),
    parameter int SUM_W  = PROD_W + 2
) (
    input  logic                                      clk,
    input  logic                                      rst_n,
    input  logic                                      up_valid,
    output logic                                      up_ready,
    input  logic [avt_pkg::NUM_ELEMS-1:0][PROD_W-1:0] prod,
    input  logic                                      up_homo,
    output logic                                      dn_valid,
    input  logic                                      dn_ready,
    output logic [avt_pkg::DIM-1:0][SUM_W-1:0]        rows,
    output logic                                      dn_homo
);

    localparam int PAIR_W  = PROD_W + 1;
    localparam int NUM_PAIRS = 2 * avt_pkg::DIM;

    logic                                 pair_valid_reg;
    logic                                 pair_adv;
    logic [NUM_PAIRS-1:0][PAIR_W-1:0]     pair_reg;
    logic [NUM_PAIRS-1:0][PAIR_W-1:0]     pair_next;
    logic                                 pair_homo_reg;
    logic                                 row_valid_reg;
    logic                                 row_adv;
    logic [avt_pkg::DIM-1:0][SUM_W-1:0]   row_reg;
    logic [avt_pkg::DIM-1:0][SUM_W-1:0]   row_next;
    logic                                 row_homo_reg;

    assign row_adv  = !row_valid_reg || dn_ready;
    assign pair_adv = !pair_valid_reg || row_adv;
    assign up_ready = pair_adv;

    // Add neighbouring products with sign extension
    always_comb
    begin
        for (int j = 0; j < NUM_PAIRS; j++)
        begin
            pair_next[j] = PAIR_W'($signed(prod[2*j])) + PAIR_W'($signed(prod[2*j + 1]));
        end
    end

    // Add the two pairs of each row
    always_comb
    begin
        for (int r = 0; r < avt_pkg::DIM; r++)
        begin
            row_next[r] = SUM_W'($signed(pair_reg[2*r])) + SUM_W'($signed(pair_reg[2*r + 1]));
        end
    end

    // Advance both valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pair_valid_reg <= 1'b0;
            row_valid_reg  <= 1'b0;
        end
        else
        begin
            if (pair_adv)
                pair_valid_reg <= up_valid;
            if (row_adv)
                row_valid_reg <= pair_valid_reg;
        end
    end

    // Hold the partial sums
    always_ff @(posedge clk)
    begin
        if (pair_adv && up_valid)
        begin
            pair_reg      <= pair_next;
            pair_homo_reg <= up_homo;
        end
        if (row_adv && pair_valid_reg)
        begin
            row_reg      <= row_next;
            row_homo_reg <= pair_homo_reg;
        end
    end

    assign dn_valid = row_valid_reg;
    assign rows     = row_reg;
    assign dn_homo  = row_homo_reg;

endmodule

### rtl/core/avt_sat_stage.sv
// Last pipeline stage: drop the fraction bits, saturate, register the result.
// Depends on avt_pkg; takes row sums from avt_sum_tree.
module avt_sat_stage #(
    parameter int NUM_WIDTH = avt_pkg::NUM_WIDTH_DEF,
    parameter int FRAC_BITS = avt_pkg::FRAC_BITS_DEF,
    parameter int SUM_W     = avt_pkg::prod_width(NUM_WIDTH, FRAC_BITS) + 2
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               up_valid,
    output logic                               up_ready,
    input  logic [avt_pkg::DIM-1:0][SUM_W-1:0] rows,
    input  logic                               homo,
    output logic                               res_valid,
    input  logic                               res_ready,
    output avt_pkg::avt_out_t                  res_data
);

    localparam logic signed [SUM_W-1:0] SAT_HI = SUM_W'({1'b0, {(NUM_WIDTH-1){1'b1}}});
    localparam logic signed [SUM_W-1:0] SAT_LO = ~SAT_HI;

    logic                             valid_reg;
    logic                             advance;
    avt_pkg::avt_out_t                res_reg;
    avt_pkg::avt_out_t                res_next;
    logic signed [SUM_W-1:0]          quot [avt_pkg::DIM];
    logic signed [NUM_WIDTH-1:0]      sat_val [avt_pkg::DIM];
    logic [avt_pkg::DIM-1:0]          sat_hit;

    assign advance  = !valid_reg || res_ready;
    assign up_ready = advance;

    // Shift toward minus infinity and clamp each row
    always_comb
    begin
        for (int r = 0; r < avt_pkg::DIM; r++)
        begin
            quot[r] = $signed(rows[r]) >>> FRAC_BITS;
            if (quot[r] > SAT_HI)
            begin
                sat_val[r] = SAT_HI[NUM_WIDTH-1:0];
                sat_hit[r] = 1'b1;
            end
            else if (quot[r] < SAT_LO)
            begin
                sat_val[r] = SAT_LO[NUM_WIDTH-1:0];
                sat_hit[r] = 1'b1;
            end
            else
            begin
                sat_val[r] = quot[r][NUM_WIDTH-1:0];
                sat_hit[r] = 1'b0;
            end
        end
    end

    // Assemble the result; w is zero and never flags outside homogeneous mode
    always_comb
    begin
        res_next.out_x    = avt_pkg::FIELD_W'(sat_val[0]);
        res_next.out_y    = avt_pkg::FIELD_W'(sat_val[1]);
        res_next.out_z    = avt_pkg::FIELD_W'(sat_val[2]);
        res_next.out_w    = homo ? avt_pkg::FIELD_W'(sat_val[3]) : '0;
        res_next.overflow = sat_hit[0] || sat_hit[1] || sat_hit[2] || (homo && sat_hit[3]);
    end

    // Advance the output valid bit
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (advance)
            valid_reg <= up_valid;
    end

    // Load the output register
    always_ff @(posedge clk)
    begin
        if (advance && up_valid)
            res_reg <= res_next;
    end

    assign res_valid = valid_reg;
    assign res_data  = res_reg;

endmodule

### rtl/core/affine_vector_transform.sv
// Affine vector transform: 4x4 signed fixed-point matrix times a vector.
// Pipeline stages from request acceptance to result valid: products, pair sums,
// row sums, shift and saturate. Throughput: one vector per cycle while res_ready
// holds, set by the sixteen parallel multipliers of the first stage; stalls back-fill
// empty stages. Reset clears every stage valid bit and loads the identity matrix.
// Depends on avt_pkg, avt_cfg_regs, avt_mult_stage, avt_sum_tree, avt_sat_stage.
module affine_vector_transform #(
    parameter int NUM_WIDTH = avt_pkg::NUM_WIDTH_DEF,
    parameter int FRAC_BITS = avt_pkg::FRAC_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [avt_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [avt_pkg::CFG_W-1:0]     cfg_data,
    input  logic                          vec_valid,
    output logic                          vec_ready,
    input  avt_pkg::avt_in_t              vec_data,
    output logic                          res_valid,
    input  logic                          res_ready,
    output avt_pkg::avt_out_t             res_data
);

    localparam int PROD_W = avt_pkg::prod_width(NUM_WIDTH, FRAC_BITS);
    localparam int SUM_W  = PROD_W + 2;
    localparam logic signed [avt_pkg::FIELD_W-1:0] RES_MAX =
        avt_pkg::FIELD_W'({1'b0, {(NUM_WIDTH-1){1'b1}}});
    localparam logic signed [avt_pkg::FIELD_W-1:0] RES_MIN = ~RES_MAX;

    logic [avt_pkg::NUM_ELEMS-1:0][NUM_WIDTH-1:0] mat;
    logic                                         prod_valid;
    logic                                         prod_ready;
    logic [avt_pkg::NUM_ELEMS-1:0][PROD_W-1:0]    prod;
    logic                                         prod_homo;
    logic                                         sum_valid;
    logic                                         sum_ready;
    logic [avt_pkg::DIM-1:0][SUM_W-1:0]           rows;
    logic                                         sum_homo;

    // Matrix registers
    avt_cfg_regs #(
        .NUM_WIDTH (NUM_WIDTH)
    ) u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .mat       (mat)
    );

    // Products
    avt_mult_stage #(
        .NUM_WIDTH (NUM_WIDTH),
        .FRAC_BITS (FRAC_BITS),
        .PROD_W    (PROD_W)
    ) u_mult (
        .clk      (clk),
        .rst_n    (rst_n),
        .mat      (mat),
        .up_valid (vec_valid),
        .up_ready (vec_ready),
        .item     (vec_data),
        .dn_valid (prod_valid),
        .dn_ready (prod_ready),
        .prod     (prod),
        .homo     (prod_homo)
    );

    // Row sums
    avt_sum_tree #(
        .PROD_W (PROD_W),
        .SUM_W  (SUM_W)
    ) u_sum (
        .clk      (clk),
        .rst_n    (rst_n),
        .up_valid (prod_valid),
        .up_ready (prod_ready),
        .prod     (prod),
        .up_homo  (prod_homo),
        .dn_valid (sum_valid),
        .dn_ready (sum_ready),
        .rows     (rows),
        .dn_homo  (sum_homo)
    );

    // Shift, saturate and present the result
    avt_sat_stage #(
        .NUM_WIDTH (NUM_WIDTH),
        .FRAC_BITS (FRAC_BITS),
        .SUM_W     (SUM_W)
    ) u_sat (
        .clk       (clk),
        .rst_n     (rst_n),
        .up_valid  (sum_valid),
        .up_ready  (sum_ready),
        .rows      (rows),
        .homo      (sum_homo),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res_data  (res_data)
    );

    // A draining output lets a request pass product, pair, row and output registers
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (vec_valid && vec_ready) ##1 res_ready ##1 res_ready ##1 res_ready |=> res_valid)
        else $error("request did not reach the output in four cycles");

    // An overflow flag needs at least one component at a saturation bound
    a_ovf_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && res_data.overflow) |->
            (res_data.out_x == RES_MAX || res_data.out_x == RES_MIN ||
             res_data.out_y == RES_MAX || res_data.out_y == RES_MIN ||
             res_data.out_z == RES_MAX || res_data.out_z == RES_MIN ||
             res_data.out_w == RES_MAX || res_data.out_w == RES_MIN))
        else $error("overflow flagged without a saturated component");

    // A full product stage held by the sum tree must still be full next cycle
    a_prod_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (prod_valid && !prod_ready) |=> prod_valid)
        else $error("product stage dropped a stalled request");

endmodule
